// ===== sv/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Deframer package
// Shared types and constants for the sync-framed sample deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int unsigned SAMPLES_DEFAULT = 150;
    localparam int unsigned QUEUE_DEPTH     = 4;

    localparam logic [7:0] SYNC0 = 8'hDE;
    localparam logic [7:0] SYNC1 = 8'hAD;
    localparam logic [7:0] SYNC2 = 8'hBE;
    localparam logic [7:0] SYNC3 = 8'hEF;

    localparam logic [1:0] KIND_SAMPLE   = 2'd0;
    localparam logic [1:0] KIND_FRAME_OK = 2'd1;
    localparam logic [1:0] KIND_FRAME_BAD = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  sample_index;
        logic [15:0] sample_value;
        logic        last;
    } t_result;

endpackage

// ===== sv/sfd_front.sv =====
// ----------------------------------------------------------------------------
// Deframer front end
// Hunts for the sync word, assembles payload samples, checks the frame sum.
// ----------------------------------------------------------------------------
module sfd_front #(
    parameter int unsigned SAMPLES = sfd_pkg::SAMPLES_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    output logic             o_res_valid,
    output sfd_pkg::t_result o_res
);
    import sfd_pkg::*;

    localparam int unsigned CntW = $clog2(2 * SAMPLES + 1);
    localparam logic [CntW-1:0] CntLast = CntW'(2 * SAMPLES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GOT_DE,
        S_GOT_AD,
        S_GOT_BE,
        S_PAYLOAD,
        S_CHECK
    } t_state;

    t_state          r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [7:0]      r_low, n_low;
    logic [7:0]      r_sum, n_sum;
    logic [CntW+7:0] cnt_ext;

    assign cnt_ext = {8'd0, r_cnt};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_low       = r_low;
        n_sum       = r_sum;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            unique case (r_state)
                S_PAYLOAD: begin
                    n_sum = r_sum + i_data_byte;
                    n_cnt = r_cnt + 1'b1;
                    if (!r_cnt[0]) begin
                        n_low = i_data_byte;
                    end else begin
                        o_res_valid        = 1'b1;
                        o_res.kind         = KIND_SAMPLE;
                        o_res.sample_index = cnt_ext[8:1];
                        o_res.sample_value = {i_data_byte, r_low};
                        if (r_cnt == CntLast) begin
                            n_state = S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    o_res_valid = 1'b1;
                    o_res.kind  = (i_data_byte == r_sum) ? KIND_FRAME_OK : KIND_FRAME_BAD;
                    o_res.last  = 1'b1;
                    n_state     = S_IDLE;
                end
                S_GOT_BE: begin
                    if (i_data_byte == SYNC3) begin
                        n_state = S_PAYLOAD;
                        n_cnt   = '0;
                        n_sum   = '0;
                    end else if (i_data_byte == SYNC0) begin
                        n_state = S_GOT_DE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
                S_GOT_AD: begin
                    if (i_data_byte == SYNC2) begin
                        n_state = S_GOT_BE;
                    end else if (i_data_byte == SYNC0) begin
                        n_state = S_GOT_DE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
                S_GOT_DE: begin
                    if (i_data_byte == SYNC1) begin
                        n_state = S_GOT_AD;
                    end else if (i_data_byte == SYNC0) begin
                        n_state = S_GOT_DE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
                default: begin
                    n_state = (i_data_byte == SYNC0) ? S_GOT_DE : S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
        end
        r_low <= n_low;
    end

endmodule

// ===== sv/sfd_queue.sv =====
// ----------------------------------------------------------------------------
// Deframer result queue
// Small first-in first-out buffer that holds results until they are popped.
// ----------------------------------------------------------------------------
module sfd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  sfd_pkg::t_result i_wr_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output sfd_pkg::t_result o_rd_data
);
    import sfd_pkg::*;

    localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

    t_result         r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            rd;

    assign o_full    = (r_count == CntW'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign rd        = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !i_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ===== sv/sync_framed_sample_deframer_core.sv =====
// ----------------------------------------------------------------------------
// Sync-framed sample deframer
// Parses DE AD BE EF framed byte streams into samples and frame-end reports.
// ----------------------------------------------------------------------------
// A result is registered in the result queue and reaches the output ports once it is at the head of the queue.
// Throughput: one byte beat per cycle while the four-entry result queue has room.
// The queue between the parser and the output sets the stall behaviour.
// Reset is synchronous and active low; it clears the hunt state and the queue.
module sync_framed_sample_deframer_core #(
    parameter int unsigned SAMPLES = sfd_pkg::SAMPLES_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_sample_index,
    output logic [15:0] o_sample_value,
    output logic        o_last
);
    import sfd_pkg::*;

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result head;

    assign accept = push && !full;

    sfd_front #(
        .SAMPLES (SAMPLES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sfd_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (res_valid),
        .i_wr_data (res),
        .i_pop     (pop),
        .o_full    (full),
        .o_empty   (empty),
        .o_rd_data (head)
    );

    assign o_kind         = head.kind;
    assign o_sample_index = head.sample_index;
    assign o_sample_value = head.sample_value;
    assign o_last         = head.last;

endmodule

// ===== sv/sfd_checker.sv =====
// ----------------------------------------------------------------------------
// Deframer port checker
// Checks result consistency and queue behaviour seen at the top-level ports.
// ----------------------------------------------------------------------------
module sfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic [7:0]  i_data_byte,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_sample_index,
    input logic [15:0] o_sample_value,
    input logic        o_last
);
    import sfd_pkg::*;

    a_frame_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last) |-> (o_kind == KIND_FRAME_OK || o_kind == KIND_FRAME_BAD))
        else $error("frame-end beat carries a sample kind");

    a_frame_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last) |-> (o_sample_index == 8'd0 && o_sample_value == 16'd0))
        else $error("frame-end beat carries sample data");

    a_sample_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last) |-> (o_kind == KIND_SAMPLE))
        else $error("sample beat carries a frame-end kind");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !(push && !full)) |=> empty)
        else $error("result appeared without an input beat");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (full && !pop) |=> full)
        else $error("queue lost an entry while stalled");

endmodule

bind sync_framed_sample_deframer_core sfd_checker u_sfd_checker (.*);
